FILE: hw/rtl/qwd_pkg.sv
// qwd_pkg: shared widths, register indexes, symbol codes and types
// for the qpsk window demodulator; no dependencies
`timescale 1ns / 1ps

package qwd_pkg;

    // fixed payload and register widths
    localparam int SUM_W      = 22;
    localparam int CNT_W      = 6;
    localparam int SYM_W      = 2;
    localparam int PHASE_W    = 32;
    localparam int LG_CFG_W   = 3;
    localparam int SKIP_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TRIG_W     = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_LG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP       = 2'd2;

    // register reset values
    localparam logic [LG_CFG_W-1:0] SYMBOL_LG_RESET = 3'd3;

    // decided dibits
    localparam logic [SYM_W-1:0] SYM_RIGHT = 2'd0;
    localparam logic [SYM_W-1:0] SYM_UP    = 2'd1;
    localparam logic [SYM_W-1:0] SYM_LEFT  = 2'd2;
    localparam logic [SYM_W-1:0] SYM_DOWN  = 2'd3;

    // q30 constants for the sine rom build
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] TRIG_MAX    = 64'd32767;

    // taylor term divisors n*(n-1) for n = 17, 15, ..., 3
    localparam int unsigned TaylorDiv [8] = '{272, 210, 156, 110, 72, 42, 20, 6};

    // per-sample control that travels along the data pipeline
    typedef struct packed {
        logic clr_pre;
        logic add;
        logic emit;
        logic clr_post;
    } t_ctl;

endpackage

FILE: hw/rtl/qwd_if.sv
// qwd_if: valid/ready channels of the qpsk window demodulator
// (sample beats, result beats, configuration writes); uses qwd_pkg
`timescale 1ns / 1ps

interface qwd_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;
    logic                          stream_end;

    modport source (output valid, output sample_i, output sample_q, output stream_end,
                    input ready);
    modport sink   (input valid, input sample_i, input sample_q, input stream_end,
                    output ready);
endinterface

interface qwd_result_if;
    import qwd_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [SYM_W-1:0]        symbol_bits;
    logic signed [SUM_W-1:0] sum_i;
    logic signed [SUM_W-1:0] sum_q;
    logic [CNT_W-1:0]        window_count;

    modport source (output valid, output symbol_bits, output sum_i, output sum_q,
                    output window_count, input ready);
    modport sink   (input valid, input symbol_bits, input sum_i, input sum_q,
                    input window_count, output ready);
endinterface

interface qwd_cfg_if;
    import qwd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/qpsk_window_demodulator.sv
// qpsk_window_demodulator: nco mix-down, mid-symbol window sums and dibit decision
// Stages 1 to 4 carry the sample beat that closes a window to the output register.
// Throughput: one sample per cycle unless stalled, set by the two-port sine rom
// with registered read, one multiplier stage, one rounding add and one accumulator.
// Reset (i_rst_n low, synchronous) clears the pipeline, the stream state and the
// registers to their defaults; the sine rom is a constant and needs no fill.
`timescale 1ns / 1ps

module qpsk_window_demodulator #(
    parameter int SINE_TABLE_ENTRIES     = 1024,
    parameter int SAMPLE_BITS            = 16,
    parameter int MAX_SYMBOL_LENGTH_LOG2 = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qwd_sample_if.sink    i_sample,
    qwd_result_if.source  o_result,
    qwd_cfg_if.sink       i_cfg
);
    import qwd_pkg::*;

    localparam int TBITS    = $clog2(SINE_TABLE_ENTRIES);
    localparam int QTR      = SINE_TABLE_ENTRIES / 4;
    localparam int QTR_BITS = TBITS - 2;
    localparam int POS_W    = MAX_SYMBOL_LENGTH_LOG2;
    localparam int LG_W     = ($clog2(MAX_SYMBOL_LENGTH_LOG2 + 1) > LG_CFG_W) ?
                              $clog2(MAX_SYMBOL_LENGTH_LOG2 + 1) : LG_CFG_W;
    localparam int PROD_W   = SAMPLE_BITS + TRIG_W;
    localparam int WIDE_W   = PROD_W + SUM_W + 1;

    typedef logic signed [TRIG_W-1:0] t_rom [SINE_TABLE_ENTRIES];

    // quarter-wave sine by q30 taylor series, scaled to q15 with rounding
    function automatic logic [TRIG_W-1:0] quarter_sine(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        x  = (64'(k) * Q30_HALF_PI + 64'(QTR / 2)) >> QTR_BITS;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int j = 0; j < 8; j++) begin
            t = Q30_ONE - (((x2 * t) >> 30) / 64'(TaylorDiv[j]));
        end
        v = (x * t) >> 30;
        v = (v * TRIG_MAX + (64'd1 << 29)) >> 30;
        if (v > TRIG_MAX) begin
            v = TRIG_MAX;
        end
        return v[TRIG_W-1:0];
    endfunction

    // full sine table mirrored from the quarter wave
    function automatic t_rom build_rom();
        t_rom        rom;
        logic [TRIG_W-1:0] v;
        for (int k = 0; k <= QTR; k++) begin
            v = quarter_sine(k);
            rom[TBITS'(k)]                            = v;
            rom[TBITS'(SINE_TABLE_ENTRIES / 2 - k)]   = v;
            rom[TBITS'(SINE_TABLE_ENTRIES / 2 + k)]   = -v;
            rom[TBITS'(SINE_TABLE_ENTRIES - k)]       = -v;
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    // dibit decision from sign and magnitude of the window sums
    function automatic logic [SYM_W-1:0] decide(input logic signed [SUM_W-1:0] sa,
                                                input logic signed [SUM_W-1:0] sb,
                                                input logic [CNT_W-1:0] cnt);
        logic signed [SUM_W:0] a;
        logic signed [SUM_W:0] b;
        logic [SYM_W-1:0]      sym;
        a = (SUM_W+1)'(sa);
        b = (SUM_W+1)'(sb);
        if (cnt == '0) begin
            sym = SYM_DOWN;
        end else if (a == '0 && b == '0) begin
            sym = SYM_RIGHT;
        end else if (b < a && b >= -a) begin
            sym = SYM_RIGHT;
        end else if (b >= a && b > -a) begin
            sym = SYM_UP;
        end else if (a >= b && a < -b) begin
            sym = SYM_LEFT;
        end else begin
            sym = SYM_DOWN;
        end
        return sym;
    endfunction

    // configuration registers
    logic [PHASE_W-1:0]  r_phase_inc;
    logic [LG_CFG_W-1:0] r_symbol_lg;
    logic [SKIP_W-1:0]   r_skip_samples;

    // stream state
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [SKIP_W-1:0]   r_skip_cnt, n_skip_cnt;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_wdone, n_wdone;

    // pipeline
    logic                          w_adv;
    logic                          w_accept;
    t_ctl                          w_ctl;
    logic [CNT_W-1:0]              w_cnt_out;

    logic                          r1_vld;
    t_ctl                          r1_ctl;
    logic [CNT_W-1:0]              r1_cnt;
    logic signed [SAMPLE_BITS-1:0] r1_xi, r1_xq;
    logic signed [TRIG_W-1:0]      r1_sin, r1_cos;

    logic                          r2_vld;
    t_ctl                          r2_ctl;
    logic [CNT_W-1:0]              r2_cnt;
    logic signed [PROD_W-1:0]      r2_p_ic, r2_p_qs, r2_p_qc, r2_p_is;

    logic                          r3_vld;
    t_ctl                          r3_ctl;
    logic [CNT_W-1:0]              r3_cnt;
    logic signed [SUM_W-1:0]       r3_bi, r3_bq;

    logic signed [SUM_W-1:0]       r_acc_i, r_acc_q;
    logic signed [SUM_W-1:0]       w_sum_i, w_sum_q;

    logic                          r4_vld;
    logic [CNT_W-1:0]              r4_cnt;
    logic signed [SUM_W-1:0]       r4_sum_i, r4_sum_q;

    logic                          r_out_vld;
    logic [SYM_W-1:0]              r_out_sym;
    logic [CNT_W-1:0]              r_out_cnt;
    logic signed [SUM_W-1:0]       r_out_sum_i, r_out_sum_q;

    // configuration write port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc    <= '0;
            r_symbol_lg    <= SYMBOL_LG_RESET;
            r_skip_samples <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PHASE_INC: r_phase_inc    <= i_cfg.data[PHASE_W-1:0];
                REG_SYMBOL_LG: r_symbol_lg    <= i_cfg.data[LG_CFG_W-1:0];
                REG_SKIP:      r_skip_samples <= i_cfg.data[SKIP_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advances whenever the output register is free or being taken
    assign w_adv          = !r_out_vld || o_result.ready;
    assign i_sample.ready = w_adv;
    assign w_accept       = i_sample.valid && w_adv;

    // symbol geometry from the clamped length
    logic [LG_W-1:0]  w_lg_raw, w_lg;
    logic [POS_W:0]   w_sps, w_ws, w_we, w_pos_ext, w_pos_inc;
    logic             w_skipping, w_in_win, w_last;

    assign w_lg_raw = LG_W'(r_symbol_lg);

    always_comb begin
        if (w_lg_raw < LG_W'(1)) begin
            w_lg = LG_W'(1);
        end else if (w_lg_raw > LG_W'(MAX_SYMBOL_LENGTH_LOG2)) begin
            w_lg = LG_W'(MAX_SYMBOL_LENGTH_LOG2);
        end else begin
            w_lg = w_lg_raw;
        end
    end

    assign w_sps      = (POS_W+1)'(1) << w_lg;
    assign w_ws       = w_sps >> 2;
    assign w_we       = w_ws + (w_sps >> 1);
    assign w_pos_ext  = (POS_W+1)'(r_pos);
    assign w_pos_inc  = w_pos_ext + (POS_W+1)'(1);
    assign w_skipping = r_skip_cnt < r_skip_samples;
    assign w_last     = i_sample.stream_end;
    assign w_in_win   = !r_wdone && (w_pos_ext >= w_ws) && (w_pos_ext < w_we);

    // stream control, decided when the sample beat is accepted
    always_comb begin
        logic [CNT_W-1:0] cnt_new;
        n_phase    = r_phase;
        n_skip_cnt = r_skip_cnt;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_wdone    = r_wdone;
        w_ctl      = '0;
        w_cnt_out  = '0;
        cnt_new    = r_cnt + CNT_W'(w_in_win);
        if (w_accept) begin
            if (w_skipping) begin
                w_ctl.clr_pre  = 1'b1;
                w_ctl.emit     = w_last;
                w_ctl.clr_post = 1'b1;
                n_phase        = '0;
                n_pos          = '0;
                n_cnt          = '0;
                n_wdone        = 1'b0;
                n_skip_cnt     = w_last ? '0 : r_skip_cnt + SKIP_W'(1);
            end else begin
                w_ctl.add  = w_in_win;
                w_ctl.emit = (w_in_win && (w_pos_inc == w_we || w_last)) ||
                             (!w_in_win && w_last && !r_wdone);
                w_cnt_out  = cnt_new;
                n_cnt      = cnt_new;
                n_wdone    = r_wdone || w_ctl.emit;
                n_phase    = r_phase + r_phase_inc;
                if (w_pos_inc >= w_sps) begin
                    w_ctl.clr_post = 1'b1;
                    n_pos          = '0;
                    n_cnt          = '0;
                    n_wdone        = 1'b0;
                end else begin
                    n_pos = w_pos_inc[POS_W-1:0];
                end
                if (w_last) begin
                    w_ctl.clr_post = 1'b1;
                    n_phase        = '0;
                    n_skip_cnt     = '0;
                    n_pos          = '0;
                    n_cnt          = '0;
                    n_wdone        = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_skip_cnt <= '0;
            r_pos      <= '0;
            r_cnt      <= '0;
            r_wdone    <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_skip_cnt <= n_skip_cnt;
            r_pos      <= n_pos;
            r_cnt      <= n_cnt;
            r_wdone    <= n_wdone;
        end
    end

    // rom addresses for sine and cosine from the top phase bits
    logic [TBITS-1:0] w_idx, w_cidx;
    assign w_idx  = r_phase[PHASE_W-1 -: TBITS];
    assign w_cidx = w_idx + TBITS'(QTR);

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld    <= w_accept;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld && r3_ctl.emit;
            r_out_vld <= r4_vld;
        end
    end

    // stage 1: sample register and registered rom read
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_ctl <= w_ctl;
            r1_cnt <= w_cnt_out;
            r1_xi  <= i_sample.sample_i;
            r1_xq  <= i_sample.sample_q;
            r1_sin <= SINE_ROM[w_idx];
            r1_cos <= SINE_ROM[w_cidx];
        end
    end

    // stage 2: four mixer products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_ctl  <= r1_ctl;
            r2_cnt  <= r1_cnt;
            r2_p_ic <= PROD_W'(r1_xi * r1_cos);
            r2_p_qs <= PROD_W'(r1_xq * r1_sin);
            r2_p_qc <= PROD_W'(r1_xq * r1_cos);
            r2_p_is <= PROD_W'(r1_xi * r1_sin);
        end
    end

    // stage 3: combine and round off the q15 trig scale, wrapped to the sum width
    logic signed [PROD_W:0]   w_rnd_i, w_rnd_q;
    logic signed [WIDE_W-1:0] w_bi_wide, w_bq_wide;

    assign w_rnd_i   = (PROD_W+1)'(r2_p_ic) + (PROD_W+1)'(r2_p_qs)
                       + (PROD_W+1)'(1 << 14);
    assign w_rnd_q   = (PROD_W+1)'(r2_p_qc) - (PROD_W+1)'(r2_p_is)
                       + (PROD_W+1)'(1 << 14);
    assign w_bi_wide = WIDE_W'(w_rnd_i >>> 15);
    assign w_bq_wide = WIDE_W'(w_rnd_q >>> 15);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_ctl <= r2_ctl;
            r3_cnt <= r2_cnt;
            r3_bi  <= w_bi_wide[SUM_W-1:0];
            r3_bq  <= w_bq_wide[SUM_W-1:0];
        end
    end

    // stage 4: window accumulators
    assign w_sum_i = (r3_ctl.clr_pre ? '0 : r_acc_i) + (r3_ctl.add ? r3_bi : '0);
    assign w_sum_q = (r3_ctl.clr_pre ? '0 : r_acc_q) + (r3_ctl.add ? r3_bq : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (w_adv && r3_vld) begin
            r_acc_i <= r3_ctl.clr_post ? '0 : w_sum_i;
            r_acc_q <= r3_ctl.clr_post ? '0 : w_sum_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_cnt   <= r3_cnt;
            r4_sum_i <= w_sum_i;
            r4_sum_q <= w_sum_q;
        end
    end

    // stage 5: decision and output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_sym   <= decide(r4_sum_i, r4_sum_q, r4_cnt);
            r_out_cnt   <= r4_cnt;
            r_out_sum_i <= r4_sum_i;
            r_out_sum_q <= r4_sum_q;
        end
    end

    // result beat
    assign o_result.valid        = r_out_vld;
    assign o_result.symbol_bits  = r_out_sym;
    assign o_result.sum_i        = r_out_sum_i;
    assign o_result.sum_q        = r_out_sum_q;
    assign o_result.window_count = r_out_cnt;

endmodule
